// ----- rtl/core/dgfsm_pkg.sv -----
// Package for the dual GNSS fix-selecting mux.
// Parser phase type, NMEA character constants and the update request struct.
// No dependencies.
package dgfsm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CommasW  = 4;

  localparam logic [ByteW-1:0]   StartChar  = 8'h24;  // '$'
  localparam logic [ByteW-1:0]   CommaChar  = 8'h2C;  // ','
  localparam logic [ByteW-1:0]   ZeroChar   = 8'h30;  // '0'
  localparam logic [IdxW-1:0]    PrefixLen  = 4'd5;   // "GPGGA"
  localparam logic [CommasW-1:0] CommasRst  = 4'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_FIELD  = 2'd2
  } parse_phase_t;

  // One parser update: enable, the byte and the comma count in force
  typedef struct packed {
    logic               en;
    logic [ByteW-1:0]   rx_byte;
    logic [CommasW-1:0] commas;
  } parse_req_t;

  // Character of the "GPGGA" tag at a position
  function automatic logic [ByteW-1:0] gga_char(input logic [2:0] pos);
    logic [ByteW-1:0] ch;
    case (pos)
      3'd0:    ch = 8'h47;  // G
      3'd1:    ch = 8'h50;  // P
      3'd2:    ch = 8'h47;  // G
      3'd3:    ch = 8'h47;  // G
      3'd4:    ch = 8'h41;  // A
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/dgfsm_in_if.sv -----
// Input channel interface: one received byte word with source and error tag.
// Depends on dgfsm_pkg.
interface dgfsm_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [dgfsm_pkg::ByteW-1:0] rx_byte;
  logic                     line_error;

  modport source (output valid, output op, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input op, input rx_byte, input line_error, output ready);
endinterface

// ----- rtl/core/dgfsm_out_if.sv -----
// Result channel interface: forward decision, byte and both fix qualities.
// Depends on dgfsm_pkg.
interface dgfsm_out_if;
  logic                     valid;
  logic                     ready;
  logic                     forward_valid;
  logic [dgfsm_pkg::ByteW-1:0] forward_byte;
  logic [dgfsm_pkg::ByteW-1:0] fix_first;
  logic [dgfsm_pkg::ByteW-1:0] fix_second;
  logic                     any_fix;

  modport source (output valid, output forward_valid, output forward_byte,
                  output fix_first, output fix_second, output any_fix, input ready);
  modport sink   (input valid, input forward_valid, input forward_byte,
                  input fix_first, input fix_second, input any_fix, output ready);
endinterface

// ----- rtl/core/dgfsm_parser.sv -----
// Per-receiver GGA sentence parser holding phase, match index and fix quality.
// Depends on dgfsm_pkg.
module dgfsm_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dgfsm_pkg::parse_req_t       req,
  output logic [dgfsm_pkg::ByteW-1:0] fix_r,
  output logic [dgfsm_pkg::ByteW-1:0] fix_nxt
);
  import dgfsm_pkg::*;

  parse_phase_t    phase_r, phase_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    fix_nxt   = fix_r;
    if (req.en) begin
      case (phase_r)
        PH_IDLE: begin
          if (req.rx_byte == StartChar) begin
            phase_nxt = PH_PREFIX;
            idx_nxt   = '0;
          end
        end
        PH_PREFIX: begin
          if (idx_r < PrefixLen && req.rx_byte == gga_char(idx_r[2:0])) begin
            idx_nxt = idx_r + 1'b1;
          end else if (idx_r == PrefixLen) begin
            idx_nxt   = '0;
            phase_nxt = PH_FIELD;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_FIELD: begin
          // non-comma bytes before the target field are skipped
          if (idx_r < req.commas && req.rx_byte == CommaChar) begin
            idx_nxt = idx_r + 1'b1;
          end else if (idx_r == req.commas) begin
            phase_nxt = PH_IDLE;
            fix_nxt   = req.rx_byte - ZeroChar;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      fix_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      fix_r   <= fix_nxt;
    end
  end

endmodule

// ----- rtl/core/dual_gnss_fix_selecting_mux.sv -----
// Top level of the dual GNSS fix-selecting mux: input register, two parsers,
// forward decision and result register. Depends on dgfsm_pkg, dgfsm_in_if,
// dgfsm_out_if and dgfsm_parser.
//
// Usage:
//   in_ch  : one received byte word per handshake, tagged with its receiver
//            (op) and a line error flag. Error words leave parser state alone
//            and are never forwarded, but still produce a result word.
//   out_ch : one result word per input word, in order: forward flag, the byte,
//            both fix qualities after the update and an any-fix flag.
//   cfg_we/cfg_wdata : comma count before the fix field; write only while idle.
// Path: a word accepted from in_ch waits in the input register, then moves to
//   the result register and is offered on out_ch from there.
// Throughput: one word per cycle unless out_ch stalls; the parser update is
//   a single short step as the word goes from the input to the result register.
// Reset (rst_n low, synchronous): both parsers idle, fixes zero, comma
//   count 5, pipeline empty.
// Stall: when out_ch.ready is low the result holds and the input register
//   still takes one word; in_ch.ready drops only once both are full.
module dual_gnss_fix_selecting_mux (
  input  logic                          clk,
  input  logic                          rst_n,
  dgfsm_in_if.sink                      in_ch,
  dgfsm_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [dgfsm_pkg::CommasW-1:0] cfg_wdata
);
  import dgfsm_pkg::*;

  // config register
  logic [CommasW-1:0] commas_r;

  // input register stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_op_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_err_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             fwd_r, fwd_nxt;
  logic [ByteW-1:0] byte_r;
  logic [ByteW-1:0] fix0_out_r, fix1_out_r;
  logic             any_r, any_nxt;

  logic             adv;      // word in input register moves on this edge
  logic             in_acc;
  parse_req_t       req0, req1;
  logic [ByteW-1:0] fix0_r, fix0_nxt, fix1_r, fix1_nxt;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  // route the word to its receiver's parser; error words update nothing
  always_comb begin
    req0.en      = s1_valid_r && adv && !s1_err_r && !s1_op_r;
    req0.rx_byte = s1_byte_r;
    req0.commas  = commas_r;
    req1.en      = s1_valid_r && adv && !s1_err_r && s1_op_r;
    req1.rx_byte = s1_byte_r;
    req1.commas  = commas_r;
  end

  dgfsm_parser u_parser0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req0),
    .fix_r   (fix0_r),
    .fix_nxt (fix0_nxt)
  );

  dgfsm_parser u_parser1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req1),
    .fix_r   (fix1_r),
    .fix_nxt (fix1_nxt)
  );

  // receiver 0 wins ties
  always_comb begin
    if (s1_err_r) begin
      fwd_nxt = 1'b0;
    end else if (!s1_op_r) begin
      fwd_nxt = (fix0_nxt >= fix1_nxt);
    end else begin
      fwd_nxt = (fix1_nxt > fix0_nxt);
    end
    any_nxt = (fix0_nxt != '0) || (fix1_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commas_r    <= CommasRst;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        commas_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.op;
      s1_byte_r <= in_ch.rx_byte;
      s1_err_r  <= in_ch.line_error;
    end
    if (adv && s1_valid_r) begin
      fwd_r      <= fwd_nxt;
      byte_r     <= s1_byte_r;
      fix0_out_r <= fix0_nxt;
      fix1_out_r <= fix1_nxt;
      any_r      <= any_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.forward_valid = fwd_r;
  assign out_ch.forward_byte  = byte_r;
  assign out_ch.fix_first     = fix0_out_r;
  assign out_ch.fix_second    = fix1_out_r;
  assign out_ch.any_fix       = any_r;

`ifndef SYNTHESIS
  // fixes only move when a word is handed to the result register
  a_fix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && adv) |=> ($stable(fix0_r) && $stable(fix1_r)))
    else $error("fix quality changed without a word moving");

  // result fixes agree with parser state once the pipe has drained
  a_fix_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !s1_valid_r) |-> (fix0_out_r == fix0_r && fix1_out_r == fix1_r))
    else $error("result fix differs from parser state");

  // both stages full and stalled means no new word may enter
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline full");

  // an error word is never forwarded
  a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv && s1_err_r) |=> !out_ch.forward_valid)
    else $error("error word forwarded");
`endif

endmodule

// ----- bench/dual_gnss_fix_selecting_mux_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for dual_gnss_fix_selecting_mux: directed table, then mixed GGA traffic.
// Depends on dgfsm_pkg, dgfsm_in_if, dgfsm_out_if and the RTL under rtl/core.
module dual_gnss_fix_selecting_mux_test;
  import dgfsm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no word moving on either side
  localparam int unsigned HoldCycles    = 80;    // long output back-pressure
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned DrainCycles   = 4;     // pipeline is 2 deep, leave some margin
  localparam int unsigned TailCycles    = 8;
  localparam logic [39:0] GgaTag        = "GPGGA";

  // One result word as seen on out_ch
  typedef struct packed {
    logic             fwd;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] fix_a;
    logic [ByteW-1:0] fix_b;
    logic             any;
  } mux_word_t;

  // Directed row; typed rows carry a hand-written result
  typedef struct packed {
    logic             src;
    logic [ByteW-1:0] ch;
    logic             bad;
    logic             typed;
    mux_word_t        want;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_FREE,  // always ready
    RX_COIN,  // coin flip
    RX_BEAT,  // fixed beat, one stall in three
    RX_SLOW   // mostly stalled
  } sink_mode_t;

  localparam mux_word_t NoWant = '0;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CommasW-1:0]  cfg_wdata;

  dgfsm_in_if  in_ch ();
  dgfsm_out_if out_ch ();

  dual_gnss_fix_selecting_mux dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker: our own copy of both sentence parsers and the comma count.
  // ---------------------------------------------------------------------------
  parse_phase_t       trk_phase [2];
  logic [IdxW-1:0]    trk_pos   [2];
  logic [ByteW-1:0]   trk_fix   [2];
  logic [CommasW-1:0] comma_target;

  mux_word_t pending_results [$];   // expected words, oldest first
  logic [8:0] script_a [$];         // {line_error, byte} queued for receiver 0
  logic [8:0] script_b [$];         // same for receiver 1

  bit hold_req;
  int burst_left, gap_limit, pressure_left;
  int words_in, results_seen, forwarded, bad_results, cfg_writes, holds_done;

  // Steps the tracker by one word and returns the result it should produce.
  function automatic mux_word_t predict_word(input logic src, input logic [ByteW-1:0] ch,
                                             input logic bad);
    mux_word_t w;
    int        p;
    logic      fwd;
    p   = int'(trk_pos[src]);
    fwd = 1'b0;
    if (!bad) begin
      case (trk_phase[src])
        PH_IDLE: begin
          if (ch == StartChar) begin
            trk_phase[src] = PH_PREFIX;
            trk_pos[src]   = '0;
          end
        end
        PH_PREFIX: begin
          // a mismatch drops to idle and is not looked at again as a start
          if (p < int'(PrefixLen)) begin
            if (ch == GgaTag[8*(4-p) +: 8]) trk_pos[src] = trk_pos[src] + 1'b1;
            else trk_phase[src] = PH_IDLE;
          end else if (trk_pos[src] == PrefixLen) begin
            // any character after the tag opens the fields
            trk_pos[src]   = '0;
            trk_phase[src] = PH_FIELD;
          end else begin
            trk_phase[src] = PH_IDLE;
          end
        end
        PH_FIELD: begin
          // non-commas are skipped; with a zero count the first char is the fix
          if (trk_pos[src] < comma_target && ch == CommaChar) begin
            trk_pos[src] = trk_pos[src] + 1'b1;
          end else if (trk_pos[src] == comma_target) begin
            trk_phase[src] = PH_IDLE;
            trk_fix[src]   = ch - ZeroChar;
          end
        end
        default: trk_phase[src] = PH_IDLE;
      endcase
      // receiver 0 wins ties
      fwd = src ? (trk_fix[1] > trk_fix[0]) : (trk_fix[0] >= trk_fix[1]);
    end
    w.fwd   = fwd;
    w.data  = ch;
    w.fix_a = trk_fix[0];
    w.fix_b = trk_fix[1];
    w.any   = (trk_fix[0] != '0) || (trk_fix[1] != '0);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one word, waits for the handshake, records the expectation, then
  // maybe takes a gap at the end of a burst.
  task automatic send_word(input logic src, input logic [ByteW-1:0] ch, input logic bad,
                           input logic typed, input mux_word_t want);
    mux_word_t guess;
    int        gap;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= src;
    in_ch.rx_byte    <= ch;
    in_ch.line_error <= bad;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    guess = predict_word(src, ch, bad);
    pending_results.push_back(typed ? want : guess);
    words_in++;
    if (pressure_left > 0) begin
      pressure_left--;
    end else begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(gap_limit, 0);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(12, 1);
      end
    end
  endtask

  // Drains the block, then writes the comma count.
  task automatic write_comma_count(input logic [CommasW-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    comma_target = value;
    cfg_writes++;
  endtask

  // Queues a character for one receiver; a few arrive with a line error.
  function automatic void put_char(input logic r, input logic [ByteW-1:0] ch);
    logic bad;
    bad = ($urandom_range(99, 0) < 4);
    if (bad) ch = 8'($urandom);
    if (r == 1'b0) script_a.push_back({bad, ch});
    else script_b.push_back({bad, ch});
  endfunction

  // Mostly well-formed GGA sentences with random content; some noise,
  // corrupted tags and wrong comma counts.
  task automatic append_line(input logic r);
    int               kind, n, fill;
    logic [ByteW-1:0] ch;
    kind = $urandom_range(99, 0);
    if (kind < 12) begin
      n = $urandom_range(8, 1);
      repeat (n) put_char(r, 8'($urandom));
    end else begin
      put_char(r, StartChar);
      for (int p = 0; p < 5; p++) begin
        ch = GgaTag[8*(4-p) +: 8];
        if ($urandom_range(99, 0) < 3) ch = 8'($urandom);
        put_char(r, ch);
      end
      put_char(r, ($urandom_range(3, 0) == 0) ? 8'($urandom) : CommaChar);
      n = comma_target;
      if ($urandom_range(99, 0) < 8) n = $urandom_range(15, 0);
      repeat (n) begin
        // keep long comma counts from stretching sentences too far
        fill = $urandom_range((comma_target > 8) ? 1 : 3, 0);
        repeat (fill) begin
          ch = 8'($urandom);
          if (ch == CommaChar) ch = ".";
          put_char(r, ch);
        end
        put_char(r, CommaChar);
      end
      // small fix digits so that ties and zero fixes are common
      if ($urandom_range(99, 0) < 85) put_char(r, ZeroChar + 8'($urandom_range(4, 0)));
      else put_char(r, 8'($urandom));
    end
  endtask

  task automatic send_random_word();
    logic       r;
    logic [8:0] item;
    r = 1'($urandom_range(1, 0));
    if (r == 1'b0) begin
      if (script_a.size() == 0) append_line(1'b0);
      item = script_a.pop_front();
    end else begin
      if (script_b.size() == 0) append_line(1'b1);
      item = script_b.pop_front();
    end
    send_word(r, item[7:0], item[8], 1'b0, NoWant);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, comma count at its reset value.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [0:23] = '{
    // error word right after reset: nothing moves, not forwarded
    '{1'b0, StartChar, 1'b1, 1'b1, '{1'b0, StartChar, 8'h00, 8'h00, 1'b0}},
    // byte extremes, both fixes zero: receiver 0 wins the tie, receiver 1 not
    '{1'b0, 8'hFF,     1'b0, 1'b1, '{1'b1, 8'hFF, 8'h00, 8'h00, 1'b0}},
    '{1'b1, 8'h00,     1'b0, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0}},
    // full sentence on receiver 1 with a skipped char in the fields
    '{1'b1, StartChar, 1'b0, 1'b0, NoWant},
    '{1'b1, "G",       1'b0, 1'b0, NoWant},
    '{1'b1, "P",       1'b0, 1'b0, NoWant},
    '{1'b1, "G",       1'b0, 1'b0, NoWant},
    '{1'b1, "G",       1'b0, 1'b0, NoWant},
    '{1'b1, "A",       1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    '{1'b1, "T",       1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    '{1'b1, CommaChar, 1'b0, 1'b0, NoWant},
    // '/' is one below '0': fix wraps to 0xFF
    '{1'b1, "/",       1'b0, 1'b1, '{1'b1, "/", 8'h00, 8'hFF, 1'b1}},
    '{1'b1, CommaChar, 1'b1, 1'b1, '{1'b0, CommaChar, 8'h00, 8'hFF, 1'b1}},
    // tag mismatch on '$' is not a new start, the G after it is ignored
    '{1'b0, StartChar, 1'b0, 1'b0, NoWant},
    '{1'b0, "G",       1'b0, 1'b0, NoWant},
    '{1'b0, StartChar, 1'b0, 1'b0, NoWant},
    '{1'b0, "G",       1'b0, 1'b0, NoWant},
    '{1'b0, StartChar, 1'b0, 1'b0, NoWant},
    '{1'b0, "X",       1'b0, 1'b0, NoWant}
  };

  // Random phases: comma count, words, longest sender gap (0 = no idling)
  int unsigned phase_commas [5] = '{5, 1, 15, 0, 9};
  int unsigned phase_words  [5] = '{180, 160, 250, 160, 180};
  int unsigned phase_gaps   [5] = '{6, 0, 3, 10, 4};

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = 1'b0;
    in_ch.rx_byte    = '0;
    in_ch.line_error = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    hold_req         = 1'b0;
    trk_phase[0]     = PH_IDLE;
    trk_phase[1]     = PH_IDLE;
    trk_pos[0]       = '0;
    trk_pos[1]       = '0;
    trk_fix[0]       = '0;
    trk_fix[1]       = '0;
    comma_target     = CommasRst;
    burst_left       = 1;
    gap_limit        = 4;
    pressure_left    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].src, directed_rows[i].ch, directed_rows[i].bad,
                directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      // first phase keeps the reset count; each write waits for a drained pipe
      if (ph > 0) write_comma_count(phase_commas[ph][CommasW-1:0]);
      gap_limit = phase_gaps[ph];
      for (int i = 0; i < int'(phase_words[ph]); i++) begin
        // long output hold while input keeps pushing: both stages fill
        if (ph == 1 && i == 40) begin
          hold_req      = 1'b1;
          pressure_left = 40;
        end
        send_random_word();
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d words over %0d comma settings (0 and 15 included), %0d long holds",
             words_in, cfg_writes + 1, holds_done);
    $display("checked %0d result words, %0d forwarded, %0d bad", results_seen, forwarded,
             bad_results);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("dual_gnss_fix_selecting_mux_test: clean");
    end else begin
      $display("dual_gnss_fix_selecting_mux_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output ready pacing: random modes, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    sink_mode_t mode;
    int         left;
    int         beat;
    mode         = RX_FREE;
    left         = 0;
    beat         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = sink_mode_t'($urandom_range(3, 0));
          left = $urandom_range(120, 20);
        end
        left--;
        beat++;
        case (mode)
          RX_FREE: out_ch.ready <= 1'b1;
          RX_COIN: out_ch.ready <= 1'($urandom_range(1, 0));
          RX_BEAT: out_ch.ready <= ((beat % 3) != 0);
          default: out_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mux_word_t got;
    mux_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.forward_valid, out_ch.forward_byte, out_ch.fix_first,
              out_ch.fix_second, out_ch.any_fix};
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= ReportLimit)
          $display("unexpected result word: byte %02h", got.data);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (got.fwd === 1'b1) forwarded++;
        if (got !== want) begin
          bad_results++;
          if (bad_results <= ReportLimit)
            $display({"mismatch on result %0d: expected fwd=%0b byte=%02h fix=%02h/%02h",
                      " any=%0b, got fwd=%0b byte=%02h fix=%02h/%02h any=%0b"},
                     results_seen, want.fwd, want.data, want.fix_a, want.fix_b, want.any,
                     got.fwd, got.data, got.fix_a, got.fix_b, got.any);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no word moves for too long
  // ---------------------------------------------------------------------------
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < int'(WatchdogLimit)) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
    $display("dual_gnss_fix_selecting_mux_test: errors");
    $finish;
  end

endmodule
